>>> hw/rtl/centered_boxcar_low_high_split_unit_defines.svh
// Assertion macros shared by the centered boxcar split unit.
`ifndef CENTERED_BOXCAR_LOW_HIGH_SPLIT_UNIT_DEFINES_SVH
`define CENTERED_BOXCAR_LOW_HIGH_SPLIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low.
`define CBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbx assertion failed");

// Next-cycle implication, disabled while reset is held low.
`define CBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbx assertion failed");

`endif

>>> hw/rtl/cbx_pkg.sv
// Shared constants and types of the centered boxcar split unit.
package cbx_pkg;

    localparam int WIN_W           = 6;
    localparam int WIN_RESET       = 5;
    localparam int POS_W           = 16;
    localparam int DEF_MAX_WINDOW  = 63;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_MAX_FRAME   = 65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_SUM,
        ST_CHECK,
        ST_READ,
        ST_DATA,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

>>> hw/rtl/centered_boxcar_low_high_split_unit.sv
// Top level of the centered boxcar low/high split: sequencer, delay line, divider.
//
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   i_s_tdata: sample; i_s_tlast: frame end
//  m         out        o_m_tvalid / i_m_tready   o_m_tdata: position, low, high; o_m_tlast
//  cfg       in         i_cfg_we                  i_cfg_wdata: window size
//
// A request passes through accept, drop-tap read, sum update and emit check, and each result
// through tap read, tap data, output load and emit check; an interior result of an odd window
// also passes through the serial divider.
// The last sample of a frame adds up to MAX_WINDOW/2 flushed results.
// The delay line is one memory port pair; every tap is read through it, one per read cycle.
// Synchronous active-low reset; no clearing pass, no tap older than the frame is used.
// A result waiting in the output register stalls only the next output load.
module centered_boxcar_low_high_split_unit
    import cbx_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_FRAME   = DEF_MAX_FRAME
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // [SAMPLE_BITS-1:0] sample, zero pad above
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tlast,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // [15:0] position, then low_part (SAMPLE_BITS), high_part (SAMPLE_BITS+1), zero pad
    output logic [((POS_W+2*SAMPLE_BITS+8)/8)*8-1:0] o_m_tdata,
    output logic o_m_tlast,
    input  logic i_cfg_we,
    input  logic [WIN_W-1:0] i_cfg_wdata
);

    `include "centered_boxcar_low_high_split_unit_defines.svh"

    localparam int SB    = SAMPLE_BITS;
    localparam int SUMW  = SB + WIN_W;
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OUTW  = POS_W + 2 * SB + 1;
    localparam int OTW   = ((POS_W + 2 * SB + 8) / 8) * 8;
    localparam int PADW  = OTW - OUTW;
    localparam logic [AW:0]        DEPTH_X = (AW+1)'(MAX_WINDOW);
    localparam logic [WIN_W-1:0]   WIN_MAX = WIN_W'(MAX_WINDOW);
    localparam logic [POS_W:0]     FRAME_L = (POS_W+1)'(MAX_FRAME - 1);

    t_state             r_state, n_state;
    logic [WIN_W-1:0]   r_win, n_win;
    logic [WIN_W-1:0]   r_fwin, n_fwin;
    logic [POS_W-1:0]   r_fc, n_fc;
    logic [POS_W:0]     r_em, n_em;
    logic [SUMW-1:0]    r_sum, n_sum;
    logic [AW-1:0]      r_wp, n_wp;
    logic               r_last, n_last;
    logic               r_flush, n_flush;
    logic               r_ov, n_ov;
    logic [SB-1:0]      r_x, n_x;
    logic [SB-1:0]      r_smp, n_smp;
    logic [SB-1:0]      r_low, n_low;
    logic [POS_W-1:0]   r_opos;
    logic [SB-1:0]      r_olow;
    logic [SB:0]        r_ohigh;
    logic               r_ofin;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [SB-1:0]      mem_rdata;
    logic               div_start, div_done;
    logic [SUMW-1:0]    div_quot, sum_abs, quot_signed;
    logic               out_load;
    logic [POS_W:0]     fc_x, half_x;
    logic [POS_W+1:0]   reach;
    logic               main_emit, pend_emit, edge_pos;
    logic [POS_W-1:0]   lag;
    logic [AW-1:0]      wp_inc;

    // Step back from a ring index, wrapping at the memory depth.
    function automatic logic [AW-1:0] f_back(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] diff;
        diff = {1'b0, base} - {1'b0, off};
        if (diff[AW]) begin
            diff = diff + DEPTH_X;
        end
        return diff[AW-1:0];
    endfunction

    cbx_dline #(
        .DEPTH (MAX_WINDOW),
        .DW    (SB),
        .AW    (AW)
    ) u_dline (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_x),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cbx_div #(
        .DW (SUMW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_abs),
        .i_divisor  (r_fwin),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign fc_x      = {1'b0, r_fc};
    assign half_x    = (POS_W+1)'(r_fwin >> 1);
    assign reach     = {1'b0, r_em} + {1'b0, half_x};
    assign main_emit = (r_em <= fc_x) && ((r_em < half_x) || (reach <= {1'b0, fc_x}));
    assign pend_emit = r_last && (r_em <= fc_x);
    assign edge_pos  = (r_em < half_x);
    assign lag       = r_fc - r_em[POS_W-1:0];
    assign wp_inc    = (r_wp == AW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign sum_abs   = r_sum[SUMW-1] ? (~r_sum + 1'b1) : r_sum;
    assign quot_signed = r_sum[SUMW-1] ? (~div_quot + 1'b1) : div_quot;
    assign out_load  = (r_state == ST_OUT) && (!r_ov || i_m_tready);
    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_win     = i_cfg_we ? i_cfg_wdata : r_win;
        n_fwin    = r_fwin;
        n_fc      = r_fc;
        n_em      = r_em;
        n_sum     = r_sum;
        n_wp      = r_wp;
        n_last    = r_last;
        n_flush   = r_flush;
        n_x       = r_x;
        n_smp     = r_smp;
        n_low     = r_low;
        n_ov      = r_ov && !i_m_tready;
        mem_we    = 1'b0;
        mem_waddr = wp_inc;
        mem_re    = 1'b0;
        mem_raddr = f_back(r_wp, AW'(lag));
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_x    = i_s_tdata[SB-1:0];
                    n_last = i_s_tlast || (fc_x >= FRAME_L);
                    // Latch the window and clear the sum at the first sample of a frame.
                    if (r_fc == '0) begin
                        n_fwin = (r_win > WIN_MAX) ? WIN_MAX : r_win;
                        n_sum  = '0;
                        n_em   = '0;
                    end
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                // Fetch the sample leaving the window.
                mem_re    = (r_fwin != '0);
                mem_raddr = f_back(r_wp, AW'(r_fwin - 1'b1));
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                if (r_fwin != '0) begin
                    if (r_fc >= POS_W'(r_fwin)) begin
                        n_sum = r_sum + {{WIN_W{r_x[SB-1]}}, r_x}
                                      - {{WIN_W{mem_rdata[SB-1]}}, mem_rdata};
                    end else begin
                        n_sum = r_sum + {{WIN_W{r_x[SB-1]}}, r_x};
                    end
                end
                mem_we  = 1'b1;
                n_wp    = wp_inc;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (main_emit) begin
                    n_flush = 1'b0;
                    n_state = ST_READ;
                end else if (pend_emit) begin
                    n_flush = 1'b1;
                    n_state = ST_READ;
                end else begin
                    if (r_last) begin
                        n_fc  = '0;
                        n_em  = '0;
                        n_sum = '0;
                    end else begin
                        n_fc = r_fc + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_DATA;
            end
            ST_DATA: begin
                n_smp = mem_rdata;
                if (r_flush || edge_pos) begin
                    n_low   = '0;
                    n_state = ST_OUT;
                end else if (r_fwin[0]) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end else begin
                    n_low   = mem_rdata;
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_low   = quot_signed[SB-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the output register is free.
                if (out_load) begin
                    n_ov    = 1'b1;
                    n_em    = r_em + 1'b1;
                    n_state = ST_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_win   <= WIN_W'(WIN_RESET);
            r_fwin  <= '0;
            r_fc    <= '0;
            r_em    <= '0;
            r_sum   <= '0;
            r_wp    <= '0;
            r_last  <= 1'b0;
            r_flush <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_win   <= n_win;
            r_fwin  <= n_fwin;
            r_fc    <= n_fc;
            r_em    <= n_em;
            r_sum   <= n_sum;
            r_wp    <= n_wp;
            r_last  <= n_last;
            r_flush <= n_flush;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_smp <= n_smp;
        r_low <= n_low;
        if (out_load) begin
            r_opos  <= r_em[POS_W-1:0];
            r_olow  <= r_low;
            r_ohigh <= {r_smp[SB-1], r_smp} - {r_low[SB-1], r_low};
            r_ofin  <= r_last && (r_em == fc_x);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{PADW{1'b0}}, r_ohigh, r_olow, r_opos};
    assign o_m_tlast  = r_ofin;

    `CBX_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV)
    `CBX_ASSERT_IMP(a_emit_in_frame, i_clk, i_rst_n, r_state == ST_OUT, r_em <= fc_x)
    `CBX_ASSERT_NXT(a_out_wait_holds, i_clk, i_rst_n, (r_state == ST_OUT) && !out_load, r_state == ST_OUT)
    `CBX_ASSERT_NXT(a_flush_low_zero, i_clk, i_rst_n, out_load && r_flush, r_olow == '0)

endmodule

>>> hw/rtl/cbx_dline.sv
// Sample delay line: one-write, one-read memory with registered read data.
module cbx_dline #(
    parameter int DEPTH = 63,
    parameter int DW    = 16,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cbx_div.sv
// Restoring divider, one quotient bit per cycle, unsigned dividend by window.
module cbx_div
    import cbx_pkg::*;
#(
    parameter int DW = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DW-1:0]    i_dividend,
    input  logic [WIN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DW-1:0]    o_quot
);

    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIN_W-1:0] r_rem;
    logic [DW-1:0]    r_quo;
    logic [WIN_W-1:0] r_dvs;
    logic [WIN_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Shift the dividend out of the top as quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? WIN_W'(trial - {1'b0, r_dvs}) : trial[WIN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
